// ===== hw/rtl/npcm_pkg.sv =====
// Shared types, constants and palette helpers of the nearest palette color match.
package npcm_pkg;

    localparam int CHAN_W      = 16;
    localparam int CHAN_NUM    = 3;
    localparam int LEVEL_NUM   = 4;
    localparam int PAL_ENTRIES = 16;
    localparam int IDX_W       = 4;
    localparam int Q_W         = 13;
    localparam int SQ_W        = 25;
    localparam int DIST_W      = 26;
    localparam int PIXEL_W     = 32;

    localparam logic [7:0] GLYPH_SPACE = 8'h20;
    localparam logic [7:0] GLYPH_BLOCK = 8'hDB;

    typedef logic [CHAN_W-1:0]        chan_t;
    typedef logic signed [Q_W-1:0]    q_t;
    typedef logic [SQ_W-1:0]          sq_t;
    typedef logic [DIST_W-1:0]        dist_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [PIXEL_W-1:0]       pixel_t;
    typedef logic [1:0]               level_t;
    typedef logic [1:0]               chan_sel_t;
    typedef dist_t [PAL_ENTRIES-1:0]  dist_arr_t;

    // Every palette channel takes one of four intensity levels.
    localparam chan_t LEVEL_VAL [LEVEL_NUM] = '{16'h0000, 16'h5555, 16'haaaa, 16'hffff};

    localparam chan_sel_t CH_RED   = 2'd0;
    localparam chan_sel_t CH_GREEN = 2'd1;
    localparam chan_sel_t CH_BLUE  = 2'd2;

    // Index bit 2 selects red, bit 1 green, bit 0 blue; bit 3 selects the bright half.
    function automatic level_t pal_level(idx_t idx, chan_sel_t ch);
        logic on;
        on = 1'b0;
        unique case (ch)
            CH_RED:   on = idx[2];
            CH_GREEN: on = idx[1];
            CH_BLUE:  on = idx[0];
            default:  on = 1'b0;
        endcase
        return {on, idx[3]};
    endfunction

    function automatic pixel_t make_pixel(idx_t idx);
        pixel_t pix;
        if (idx == '0)
        begin
            pix = {GLYPH_SPACE, 24'h000000};
        end
        else
        begin
            pix = {GLYPH_BLOCK, 12'h000, idx, 8'h00};
        end
        return pix;
    endfunction

endpackage

// ===== hw/rtl/npcm_if.sv =====
// Stream interfaces for the color input and the match result output.
interface npcm_in_if;
    logic           valid;
    logic           ready;
    npcm_pkg::chan_t red;
    npcm_pkg::chan_t green;
    npcm_pkg::chan_t blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface npcm_out_if;
    logic              valid;
    logic              ready;
    npcm_pkg::pixel_t  text_pixel;
    npcm_pkg::idx_t    match_index;

    modport source (output valid, output text_pixel, output match_index, input ready);
    modport sink (input valid, input text_pixel, input match_index, output ready);
endinterface

// ===== hw/rtl/npcm_dist.sv =====
// Distance pipeline: scaled channel differences, squares, and per-entry sums.
module npcm_dist (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  npcm_pkg::chan_t       red,
    input  npcm_pkg::chan_t       green,
    input  npcm_pkg::chan_t       blue,
    output logic                  out_valid,
    input  logic                  out_ready,
    output npcm_pkg::dist_arr_t   entry_dist
);
    import npcm_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    q_t        q_next  [CHAN_NUM][LEVEL_NUM];
    q_t        q_reg   [CHAN_NUM][LEVEL_NUM];
    sq_t       sq_next [CHAN_NUM][LEVEL_NUM];
    sq_t       sq_reg  [CHAN_NUM][LEVEL_NUM];
    dist_arr_t dist_next;
    dist_arr_t dist_reg;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Only the four distinct levels per channel are differenced and squared.
    always_comb
    begin
        chan_t            c;
        logic signed [16:0] d;
        for (int ch = 0; ch < CHAN_NUM; ch++)
        begin
            c = (ch == 0) ? red : ((ch == 1) ? green : blue);
            for (int lv = 0; lv < LEVEL_NUM; lv++)
            begin
                d = $signed({1'b0, c}) - $signed({1'b0, LEVEL_VAL[lv]});
                // Arithmetic shift by four is floor division by sixteen.
                q_next[ch][lv] = d[16:4];
            end
        end
    end

    always_comb
    begin
        logic signed [2*Q_W-1:0] prod;
        for (int ch = 0; ch < CHAN_NUM; ch++)
        begin
            for (int lv = 0; lv < LEVEL_NUM; lv++)
            begin
                prod = (2*Q_W)'(q_reg[ch][lv]) * (2*Q_W)'(q_reg[ch][lv]);
                sq_next[ch][lv] = prod[SQ_W-1:0];
            end
        end
    end

    always_comb
    begin
        for (int e = 0; e < PAL_ENTRIES; e++)
        begin
            dist_next[e] = {1'b0, sq_reg[0][pal_level(IDX_W'(e), CH_RED)]}
                         + {1'b0, sq_reg[1][pal_level(IDX_W'(e), CH_GREEN)]}
                         + {1'b0, sq_reg[2][pal_level(IDX_W'(e), CH_BLUE)]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            q_reg <= q_next;
        end
        if (en2)
        begin
            sq_reg <= sq_next;
        end
        if (en3)
        begin
            dist_reg <= dist_next;
        end
    end

    assign out_valid  = v3_reg;
    assign entry_dist = dist_reg;

endmodule

// ===== hw/rtl/npcm_min.sv =====
// Registered minimum tree over the sixteen distances, then text pixel encoding.
module npcm_min (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  npcm_pkg::dist_arr_t   entry_dist,
    output logic                  out_valid,
    input  logic                  out_ready,
    output npcm_pkg::pixel_t      text_pixel,
    output npcm_pkg::idx_t        match_index
);
    import npcm_pkg::*;

    localparam int GROUPS = PAL_ENTRIES / 4;

    logic v4_reg, v5_reg;
    logic en4, en5;

    dist_t  gd_next [GROUPS];
    idx_t   gi_next [GROUPS];
    dist_t  gd_reg  [GROUPS];
    idx_t   gi_reg  [GROUPS];
    idx_t   idx_next;
    idx_t   idx_reg;
    pixel_t pix_next;
    pixel_t pix_reg;

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign in_ready = en4;

    // The right operand wins only when strictly smaller, so ties keep the lower index.
    always_comb
    begin
        dist_t da, db;
        idx_t  ia, ib;
        for (int g = 0; g < GROUPS; g++)
        begin
            if (entry_dist[4*g+1] < entry_dist[4*g])
            begin
                da = entry_dist[4*g+1];
                ia = IDX_W'(4*g+1);
            end
            else
            begin
                da = entry_dist[4*g];
                ia = IDX_W'(4*g);
            end
            if (entry_dist[4*g+3] < entry_dist[4*g+2])
            begin
                db = entry_dist[4*g+3];
                ib = IDX_W'(4*g+3);
            end
            else
            begin
                db = entry_dist[4*g+2];
                ib = IDX_W'(4*g+2);
            end
            if (db < da)
            begin
                gd_next[g] = db;
                gi_next[g] = ib;
            end
            else
            begin
                gd_next[g] = da;
                gi_next[g] = ia;
            end
        end
    end

    always_comb
    begin
        dist_t da, db;
        idx_t  ia, ib;
        if (gd_reg[1] < gd_reg[0])
        begin
            da = gd_reg[1];
            ia = gi_reg[1];
        end
        else
        begin
            da = gd_reg[0];
            ia = gi_reg[0];
        end
        if (gd_reg[3] < gd_reg[2])
        begin
            db = gd_reg[3];
            ib = gi_reg[3];
        end
        else
        begin
            db = gd_reg[2];
            ib = gi_reg[2];
        end
        idx_next = (db < da) ? ib : ia;
        pix_next = make_pixel(idx_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en4)
            begin
                v4_reg <= in_valid;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            gd_reg <= gd_next;
            gi_reg <= gi_next;
        end
        if (en5)
        begin
            idx_reg <= idx_next;
            pix_reg <= pix_next;
        end
    end

    assign out_valid   = v5_reg;
    assign match_index = idx_reg;
    assign text_pixel  = pix_reg;

endmodule

// ===== hw/rtl/nearest_palette_color_match.sv =====
// Top level of the nearest palette color match: distance pipeline feeding the minimum tree.
//
// The block maps each 48-bit color (16-bit red, green, blue) to the closest entry of the
// fixed 16-color text palette, using the sum of squared channel differences scaled down
// by sixteen; on equal distances the lowest index wins. It returns the index and a text
// pixel: a space glyph for index 0, otherwise a solid block glyph with the index as the
// foreground color. It accepts one color every clock cycle unless the result side stalls,
// and each result passes through five register stages: scaled differences,
// squares, per-entry sums, and two levels each of the minimum tree. Backpressure on the
// result stalls the pipeline without losing or repeating any transfer; there is no
// configuration and no state beyond the pipeline.
module nearest_palette_color_match (
    input  logic       clk,
    input  logic       rst_n,
    npcm_in_if.sink    color,
    npcm_out_if.source match
);
    import npcm_pkg::*;

    logic      mid_valid;
    logic      mid_ready;
    dist_arr_t mid_dist;

    npcm_dist u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (color.valid),
        .in_ready   (color.ready),
        .red        (color.red),
        .green      (color.green),
        .blue       (color.blue),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .entry_dist (mid_dist)
    );

    npcm_min u_min (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (mid_valid),
        .in_ready    (mid_ready),
        .entry_dist  (mid_dist),
        .out_valid   (match.valid),
        .out_ready   (match.ready),
        .text_pixel  (match.text_pixel),
        .match_index (match.match_index)
    );

endmodule

// ===== tb/nearest_palette_color_match_test.sv =====
// Self-checking testbench of the nearest palette color match, with a directed table and random colors.
`timescale 1ns / 1ps

module nearest_palette_color_match_test;

    import npcm_pkg::*;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  known;
        idx_t  idx;
    } color_case_t;

    typedef struct packed {
        pixel_t text_pixel;
        idx_t   match_index;
    } match_t;

    localparam int DIRECTED_NUM = 25;
    localparam int RANDOM_NUM   = 600;

    // The standard text palette, entry by entry as red, green, blue.
    localparam chan_t PALETTE [PAL_ENTRIES][CHAN_NUM] = '{
        '{16'h0000, 16'h0000, 16'h0000}, '{16'h0000, 16'h0000, 16'haaaa},
        '{16'h0000, 16'haaaa, 16'h0000}, '{16'h0000, 16'haaaa, 16'haaaa},
        '{16'haaaa, 16'h0000, 16'h0000}, '{16'haaaa, 16'h0000, 16'haaaa},
        '{16'haaaa, 16'haaaa, 16'h0000}, '{16'haaaa, 16'haaaa, 16'haaaa},
        '{16'h5555, 16'h5555, 16'h5555}, '{16'h5555, 16'h5555, 16'hffff},
        '{16'h5555, 16'hffff, 16'h5555}, '{16'h5555, 16'hffff, 16'hffff},
        '{16'hffff, 16'h5555, 16'h5555}, '{16'hffff, 16'h5555, 16'hffff},
        '{16'hffff, 16'hffff, 16'h5555}, '{16'hffff, 16'hffff, 16'hffff}
    };

    // Exact hits carry their index; the rest go through the predictor.
    localparam color_case_t DIRECTED_CASES [DIRECTED_NUM] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, 4'd0},
        '{16'h0000, 16'h0000, 16'haaaa, 1'b1, 4'd1},
        '{16'h0000, 16'haaaa, 16'h0000, 1'b1, 4'd2},
        '{16'h0000, 16'haaaa, 16'haaaa, 1'b1, 4'd3},
        '{16'haaaa, 16'h0000, 16'h0000, 1'b1, 4'd4},
        '{16'haaaa, 16'h0000, 16'haaaa, 1'b1, 4'd5},
        '{16'haaaa, 16'haaaa, 16'h0000, 1'b1, 4'd6},
        '{16'haaaa, 16'haaaa, 16'haaaa, 1'b1, 4'd7},
        '{16'h5555, 16'h5555, 16'h5555, 1'b1, 4'd8},
        '{16'h5555, 16'h5555, 16'hffff, 1'b1, 4'd9},
        '{16'h5555, 16'hffff, 16'h5555, 1'b1, 4'd10},
        '{16'h5555, 16'hffff, 16'hffff, 1'b1, 4'd11},
        '{16'hffff, 16'h5555, 16'h5555, 1'b1, 4'd12},
        '{16'hffff, 16'h5555, 16'hffff, 1'b1, 4'd13},
        '{16'hffff, 16'hffff, 16'h5555, 1'b1, 4'd14},
        '{16'hffff, 16'hffff, 16'hffff, 1'b1, 4'd15},
        '{16'h0001, 16'h0000, 16'h0000, 1'b0, 4'd0},
        '{16'h555a, 16'h0000, 16'h0000, 1'b0, 4'd0},
        '{16'h5559, 16'h0000, 16'h0000, 1'b0, 4'd0},
        '{16'h2ab0, 16'h2ab0, 16'h2ab0, 1'b0, 4'd0},
        '{16'h8000, 16'h8000, 16'h8000, 1'b0, 4'd0},
        '{16'hffff, 16'h0000, 16'h0000, 1'b0, 4'd0},
        '{16'h0000, 16'hffff, 16'hffff, 1'b0, 4'd0},
        '{16'ha5a5, 16'h5a5a, 16'ha5a5, 1'b0, 4'd0},
        '{16'h000f, 16'h0010, 16'hfff0, 1'b0, 4'd0}
    };

    localparam chan_t CORNER_VALUES [12] = '{
        16'h0000, 16'h0001, 16'h000f, 16'h0010, 16'h5555, 16'h7fff,
        16'h8000, 16'haaaa, 16'hfff0, 16'hfffe, 16'hffff, 16'h5556
    };

    logic clk = 1'b0;
    logic rst_n;

    npcm_in_if  color_if ();
    npcm_out_if match_if ();

    match_t   pending_matches [$];
    int       colors_sent;
    int       matches_checked;
    int       mismatches;
    int       burst_left;
    bit [15:0] entries_chosen;

    nearest_palette_color_match u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .color (color_if),
        .match (match_if)
    );

    always #5 clk = ~clk;

    // Closest palette entry by the sum of squared, floor-scaled channel differences.
    function automatic idx_t closest_entry(chan_t r, chan_t g, chan_t b);
        chan_t color [CHAN_NUM];
        int    diff;
        int    q;
        int    total;
        int    best;
        idx_t  win;
        color[0] = r;
        color[1] = g;
        color[2] = b;
        best = 1 << 26;
        win = '0;
        for (int i = 0; i < PAL_ENTRIES; i++)
        begin
            total = 0;
            for (int ch = 0; ch < CHAN_NUM; ch++)
            begin
                diff = int'(color[ch]) - int'(PALETTE[i][ch]);
                q = diff >>> 4;
                total = total + q * q;
            end
            if (total < best)
            begin
                best = total;
                win = idx_t'(i);
            end
        end
        return win;
    endfunction

    // Holds one color on the input until its transfer, then records the match it must give.
    task automatic send_color(chan_t r, chan_t g, chan_t b, idx_t want);
        match_t m;
        color_if.valid <= 1'b1;
        color_if.red   <= r;
        color_if.green <= g;
        color_if.blue  <= b;
        do
            @(posedge clk);
        while (color_if.ready !== 1'b1);
        m.match_index = want;
        m.text_pixel = (want == '0) ? {GLYPH_SPACE, 24'h000000}
                                    : {GLYPH_BLOCK, 12'h000, want, 8'h00};
        pending_matches.push_back(m);
        colors_sent++;
    endtask

    // Ends a burst at random and idles the input for a random gap.
    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            color_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic drain_matches();
        color_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_matches.size() != 0);
    endtask

    initial
    begin
        chan_t c [CHAN_NUM];
        int    kind;
        int    entry;
        int    spread;
        int    v;
        rst_n          <= 1'b0;
        color_if.valid <= 1'b0;
        color_if.red   <= '0;
        color_if.green <= '0;
        color_if.blue  <= '0;
        colors_sent = 0;
        burst_left = 1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < DIRECTED_NUM; n++)
        begin
            send_color(DIRECTED_CASES[n].red, DIRECTED_CASES[n].green, DIRECTED_CASES[n].blue,
                       DIRECTED_CASES[n].known ? DIRECTED_CASES[n].idx
                                               : closest_entry(DIRECTED_CASES[n].red,
                                                               DIRECTED_CASES[n].green,
                                                               DIRECTED_CASES[n].blue));
            pace();
        end
        drain_matches();

        for (int n = 0; n < RANDOM_NUM; n++)
        begin
            kind = $urandom_range(0, 9);
            entry = $urandom_range(0, PAL_ENTRIES - 1);
            spread = (kind % 5 == 0) ? 1 : (kind % 5 == 1) ? 16 : (kind % 5 == 2) ? 17 :
                     (kind % 5 == 3) ? 256 : 4096;
            for (int ch = 0; ch < CHAN_NUM; ch++)
            begin
                if (kind <= 2)
                begin
                    c[ch] = chan_t'($urandom_range(0, 65535));
                end
                else if (kind <= 5)
                begin
                    // Close to one palette entry, clamped to the channel range.
                    v = int'(PALETTE[entry][ch]) + int'($urandom_range(0, 2 * spread)) - spread;
                    c[ch] = (v < 0) ? 16'h0000 : (v > 65535) ? 16'hffff : chan_t'(v);
                end
                else if (kind <= 7)
                begin
                    // Exact levels, or values halfway between two levels, where equal distances are possible.
                    if ($urandom_range(0, 2) == 0)
                    begin
                        c[ch] = LEVEL_VAL[$urandom_range(0, LEVEL_NUM - 1)];
                    end
                    else if ($urandom_range(0, 1) == 0)
                    begin
                        c[ch] = LEVEL_VAL[$urandom_range(0, 2)] + 16'h2aa8
                                + chan_t'($urandom_range(0, 15));
                    end
                    else
                    begin
                        c[ch] = LEVEL_VAL[$urandom_range(0, 1)] + 16'h5550
                                + chan_t'($urandom_range(0, 15));
                    end
                end
                else
                begin
                    c[ch] = CORNER_VALUES[$urandom_range(0, 11)];
                end
            end
            send_color(c[0], c[1], c[2], closest_entry(c[0], c[1], c[2]));
            pace();
            if (n == RANDOM_NUM / 2)
            begin
                drain_matches();
            end
        end

        drain_matches();
        repeat (12) @(posedge clk);
        $display("Sent %0d colors (%0d from the directed table) and checked %0d matches.",
                 colors_sent, DIRECTED_NUM, matches_checked);
        $display("%0d of the 16 palette entries were chosen at least once.",
                 $countones(entries_chosen));
        if (mismatches == 0 && pending_matches.size() == 0)
        begin
            $display("nearest_palette_color_match_test passed");
        end
        else
        begin
            $display("nearest_palette_color_match_test failed");
        end
        $finish;
    end

    // Result side: checks each transfer against the oldest expectation, then sets ready.
    initial
    begin
        int     cycle;
        int     mode;
        match_t want;
        match_if.ready <= 1'b0;
        matches_checked = 0;
        mismatches = 0;
        entries_chosen = '0;
        cycle = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && match_if.valid === 1'b1 && match_if.ready === 1'b1)
            begin
                if (pending_matches.size() == 0)
                begin
                    $error("match_index: result %0d with no color waiting for it",
                           match_if.match_index);
                    mismatches++;
                end
                else
                begin
                    want = pending_matches.pop_front();
                    matches_checked++;
                    entries_chosen[match_if.match_index] = 1'b1;
                    if (match_if.match_index !== want.match_index)
                    begin
                        $error("match_index: expected %0d, got %0d",
                               want.match_index, match_if.match_index);
                        mismatches++;
                    end
                    if (match_if.text_pixel !== want.text_pixel)
                    begin
                        $error("text_pixel: expected %08h, got %08h",
                               want.text_pixel, match_if.text_pixel);
                        mismatches++;
                    end
                end
            end
            // The stall pattern steps through four phases in turn; one phase in four never stalls.
            mode = (cycle / 256) % 4;
            case (mode)
                0: match_if.ready <= 1'b1;
                1: match_if.ready <= ($urandom_range(0, 3) != 0);
                2: match_if.ready <= ((cycle % 7) > 2);
                default: match_if.ready <= ($urandom_range(0, 9) < 3);
            endcase
            cycle++;
        end
    end

    initial
    begin
        #2_000_000;
        $display("nearest_palette_color_match_test failed");
        $finish;
    end

endmodule
